// File: src/rgb_led_string_frame_builder_macros.svh
// Assertion helpers for the frame builder.
`ifndef RGB_LED_STRING_FRAME_BUILDER_MACROS_SVH
`define RGB_LED_STRING_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RLSFB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Next-cycle implication, checked outside reset.
`define RLSFB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

// File: src/rlsfb_pkg.sv
package rlsfb_pkg;

    localparam int NUM_LEDS_DEF = 6;

    localparam int LEVEL_W = 5;
    localparam int COLOR_W = 24;

    localparam logic [7:0]         HDR_MARK   = 8'hE0;
    localparam logic [7:0]         START_BYTE = 8'h00;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 5'd31;

    typedef enum logic [1:0] {
        REQ_SET_ONE = 2'd0,
        REQ_SET_ALL = 2'd1,
        REQ_ALL_OFF = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_LED   = 4'b0100,
        S_END   = 4'b1000
    } t_state;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: src/rlsfb_ram.sv
module rlsfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rgb_led_string_frame_builder.sv
// Frame builder for a clocked RGB LED string. Each LED keeps a 5-bit level and a 24-bit
// color in a small one-port-read RAM. A command item (set one LED, set the level of all
// LEDs, or all off) updates that state and then streams the whole frame out, one byte per
// item: four 0x00 start bytes, then per LED 0xE0|level, blue, green, red, then four bytes
// of the end_fill register, with o_last on the final byte. A set-one command whose index
// is at or above NUM_LEDS changes nothing and returns a single item with byte 0, o_last 1
// and o_status 1; request code 3 is taken and ignored. A command is taken only in S_IDLE,
// which the block leaves for the whole frame. Bytes leave through the single output register,
// which moves one byte per cycle while the sink is ready, and each LED is read from the RAM
// while the previous LED's bytes drain.
// Commands that touch every LED are applied as read-modify-write on that same sweep.
// Per-entry valid bits stand in for the cleared reset state, so no clearing pass runs
// after reset. end_fill may be written only while no frame is in flight.
module rgb_led_string_frame_builder
    import rlsfb_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF,
    localparam int LED_AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_led_index,
    input  logic [7:0] i_brightness,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    // frame byte channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_frame_byte,
    output logic       o_last,
    output logic       o_status,
    // end_fill register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

`include "rgb_led_string_frame_builder_macros.svh"

    t_state r_state, n_state;
    logic [1:0]        r_cnt, n_cnt;           // byte within the current group of four
    logic [LED_AW-1:0] r_led_idx, n_led_idx;
    t_req              r_req, n_req;
    logic [LEVEL_W-1:0] r_lvl, n_lvl;          // level for a set-all command
    logic [7:0]        r_end_fill;
    logic [NUM_LEDS-1:0] r_vld;                // entry written since reset
    logic              r_rd_vld;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_status;

    logic               w_adv;
    logic               w_acc;
    logic               w_bad_idx;
    logic               w_push;
    logic [7:0]         w_byte;
    logic               w_last;
    logic               w_status;
    logic               w_we;
    logic [LED_AW-1:0]  w_waddr;
    t_entry             w_wdata;
    logic               w_re;
    logic [LED_AW-1:0]  w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_cur;
    t_entry             w_mod;
    logic               w_last_led;

    // The output register can take a byte when empty or draining this cycle.
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_adv;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_bad_idx  = (i_led_index >= 8'(NUM_LEDS));
    assign w_last_led = (r_led_idx == LED_AW'(NUM_LEDS - 1));
    assign o_cfg_ready = 1'b1;

    // Entry as it should leave the sweep: a never-written entry reads as zero.
    always_comb begin
        w_cur = r_rd_vld ? t_entry'(w_rdata) : '0;
        w_mod = w_cur;
        case (r_req)
            REQ_SET_ALL: w_mod.level = r_lvl;
            REQ_ALL_OFF: w_mod = '0;
            default:     w_mod = w_cur;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_led_idx = r_led_idx;
        n_req     = r_req;
        n_lvl     = r_lvl;
        w_push    = 1'b0;
        w_byte    = START_BYTE;
        w_last    = 1'b0;
        w_status  = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_led_idx;
        w_wdata   = w_mod;
        w_re      = 1'b0;
        w_raddr   = r_led_idx + LED_AW'(1);

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_req = t_req'(i_req_type);
                    n_lvl = (i_brightness > 8'(LEVEL_MAX)) ? LEVEL_MAX
                                                           : i_brightness[LEVEL_W-1:0];
                    case (t_req'(i_req_type))
                        REQ_SET_ONE: begin
                            if (w_bad_idx) begin
                                // error item in place of a frame
                                w_push   = 1'b1;
                                w_byte   = '0;
                                w_last   = 1'b1;
                                w_status = 1'b1;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = i_led_index[LED_AW-1:0];
                                w_wdata = '{level: i_brightness[LEVEL_W-1:0],
                                            red: i_red, green: i_green, blue: i_blue};
                                n_state = S_START;
                                n_cnt   = '0;
                            end
                        end
                        REQ_SET_ALL, REQ_ALL_OFF: begin
                            n_state = S_START;
                            n_cnt   = '0;
                        end
                        default: begin
                            // drop the unused request code
                        end
                    endcase
                end
            end
            S_START: begin
                w_push = w_adv;
                w_byte = START_BYTE;
                if (w_adv) begin
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        // fetch LED 0 so it is ready for the first LED byte
                        w_re      = 1'b1;
                        w_raddr   = '0;
                        n_led_idx = '0;
                        n_state   = S_LED;
                    end
                end
            end
            S_LED: begin
                w_push = w_adv;
                case (r_cnt)
                    2'd0:    w_byte = HDR_MARK | 8'(w_mod.level);
                    2'd1:    w_byte = w_mod.blue;
                    2'd2:    w_byte = w_mod.green;
                    default: w_byte = w_mod.red;
                endcase
                if (w_adv) begin
                    n_cnt = r_cnt + 2'd1;
                    // write back on the header byte; the read data holds for the rest
                    if (r_cnt == 2'd0 && r_req != REQ_SET_ONE) begin
                        w_we = 1'b1;
                    end
                    if (r_cnt == 2'd3) begin
                        if (w_last_led) begin
                            n_state = S_END;
                        end else begin
                            w_re      = 1'b1;
                            n_led_idx = r_led_idx + LED_AW'(1);
                        end
                    end
                end
            end
            S_END: begin
                w_push = w_adv;
                w_byte = r_end_fill;
                w_last = (r_cnt == 2'd3);
                if (w_adv) begin
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    rlsfb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_LEDS)
    ) u_led_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_led_idx   <= '0;
            r_req       <= REQ_NONE;
            r_end_fill  <= '0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_led_idx <= n_led_idx;
            r_req     <= n_req;
            if (i_cfg_valid && o_cfg_ready) begin
                r_end_fill <= i_cfg_data;
            end
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (w_re) begin
                r_rd_vld <= r_vld[w_raddr];
            end
            if (w_adv) begin
                r_out_valid <= w_push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl;
        if (w_adv && w_push) begin
            r_out_byte   <= w_byte;
            r_out_last   <= w_last;
            r_out_status <= w_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last       = r_out_last;
    assign o_status     = r_out_status;

    // An error item carries a zero byte and closes its own frame.
    `RLSFB_ASSERT_IMP(a_err_item, o_out_valid && o_status, o_last && (o_frame_byte == 8'h00))
    // A good set-one command starts a frame on the next cycle.
    `RLSFB_ASSERT_NXT(a_frame_start,
        w_acc && (i_req_type == REQ_SET_ONE) && !w_bad_idx, r_state == S_START)
    // The sweep never reads an entry in the cycle it is written.
    `RLSFB_ASSERT_IMP(a_no_rw_clash, w_we && w_re, w_waddr != w_raddr)

endmodule

// File: bench/rgb_led_string_frame_builder_test.sv
module rgb_led_string_frame_builder_test;
    import rlsfb_pkg::*;

    localparam int LEDS         = NUM_LEDS_DEF;
    // the accept plus the whole frame, with some slack
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    // one long sink stall, started once this many commands have gone in
    localparam int HOLD_AT      = 95;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        t_req       req;
        logic [7:0] idx;
        logic [7:0] bri;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_led_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       status;
    } t_frame_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_req_type = REQ_SET_ONE;
    logic [7:0] i_led_index = 8'h00;
    logic [7:0] i_brightness = 8'h00;
    logic [7:0] i_red = 8'h00;
    logic [7:0] i_green = 8'h00;
    logic [7:0] i_blue = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_frame_byte;
    logic       o_last;
    logic       o_status;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'h00;

    rgb_led_string_frame_builder #(.NUM_LEDS(LEDS)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_led_index  (i_led_index),
        .i_brightness (i_brightness),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Mirror of the LED string state and of the end_fill register.
    logic [LEVEL_W-1:0] lvl_model [LEDS];
    logic [COLOR_W-1:0] rgb_model [LEDS];
    logic [7:0]         fill_model = 8'h00;

    t_led_cmd   cmd_backlog [$];
    t_frame_out frame_bytes_due [$];

    int   mismatches = 0;
    int   cycle_cnt = 0;
    int   cmds_seen = 0;
    // handshakes seen at the last rising edge, for the falling-edge drivers
    logic cmd_taken = 1'b0;
    logic out_taken = 1'b0;
    logic cfg_taken = 1'b0;
    // driver and sink pacing
    logic offering = 1'b0;
    logic steady = 1'b0;
    int   cmd_gap = 0;
    int   sink_wait = 0;
    int   hold_left = 0;
    logic held_once = 1'b0;

    always #10 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
        mismatches++;
    endtask

    task automatic push_due(input logic [7:0] data, input logic last, input logic status);
        t_frame_out f;
        f.data = data;
        f.last = last;
        f.status = status;
        frame_bytes_due.push_back(f);
    endtask

    // Update the mirrored state for one command and queue the bytes it must produce.
    task automatic encode_command(input t_led_cmd c);
        logic [LEVEL_W-1:0] lv;
        if (c.req == REQ_NONE)
            return;
        // a bad index answers with a single error item and touches nothing
        if (c.req == REQ_SET_ONE && c.idx >= LEDS) begin
            push_due(8'h00, 1'b1, 1'b1);
            return;
        end
        case (c.req)
            REQ_SET_ONE: begin
                lvl_model[c.idx] = c.bri[LEVEL_W-1:0];
                rgb_model[c.idx] = {c.r, c.g, c.b};
            end
            REQ_SET_ALL: begin
                lv = (c.bri > 8'(LEVEL_MAX)) ? LEVEL_MAX : c.bri[LEVEL_W-1:0];
                for (int i = 0; i < LEDS; i++)
                    lvl_model[i] = lv;
            end
            REQ_ALL_OFF: begin
                for (int i = 0; i < LEDS; i++) begin
                    lvl_model[i] = '0;
                    rgb_model[i] = '0;
                end
            end
            default: ;
        endcase
        for (int k = 0; k < 4; k++)
            push_due(START_BYTE, 1'b0, 1'b0);
        for (int i = 0; i < LEDS; i++) begin
            push_due(HDR_MARK | 8'(lvl_model[i]), 1'b0, 1'b0);
            push_due(rgb_model[i][7:0], 1'b0, 1'b0);
            push_due(rgb_model[i][15:8], 1'b0, 1'b0);
            push_due(rgb_model[i][23:16], 1'b0, 1'b0);
        end
        for (int k = 0; k < 4; k++)
            push_due(fill_model, k == 3, 1'b0);
    endtask

    // Rising edge: record handshakes, predict on each accepted command,
    // check each accepted frame byte, and watch the cycle budget.
    always @(posedge i_clk) begin : frame_monitor
        t_led_cmd   c;
        t_frame_out want;
        cycle_cnt++;
        cmd_taken <= i_in_valid && o_in_ready;
        out_taken <= o_out_valid && i_out_ready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                fill_model = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                c.req = t_req'(i_req_type);
                c.idx = i_led_index;
                c.bri = i_brightness;
                c.r = i_red;
                c.g = i_green;
                c.b = i_blue;
                cmds_seen++;
                encode_command(c);
            end
            if (o_out_valid && i_out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    flag_mismatch("frame item with nothing due", o_frame_byte, 0);
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (o_frame_byte !== want.data)
                        flag_mismatch("frame_byte", o_frame_byte, want.data);
                    if (o_last !== want.last)
                        flag_mismatch("last", o_last, want.last);
                    if (o_status !== want.status)
                        flag_mismatch("status", o_status, want.status);
                end
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Falling edge: hold the current command until it is taken, then wait
    // out the drawn gap and offer the next one from the backlog.
    always @(negedge i_clk) begin : cmd_driver
        t_led_cmd c;
        if (i_rst_n && (!offering || cmd_taken)) begin
            offering = 1'b0;
            if (cmd_gap > 0) begin
                cmd_gap--;
            end else if (cmd_backlog.size() != 0) begin
                c = cmd_backlog.pop_front();
                i_req_type <= c.req;
                i_led_index <= c.idx;
                i_brightness <= c.bri;
                i_red <= c.r;
                i_green <= c.g;
                i_blue <= c.b;
                offering = 1'b1;
                cmd_gap = steady ? 0 : $urandom_range(0, 3);
            end
            i_in_valid <= offering;
        end
    end

    // Falling edge: drop ready for a drawn number of cycles per frame item,
    // and once, for a long stretch, so the block backs up into its input.
    always @(negedge i_clk) begin : frame_sink
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (!held_once && cmds_seen >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                if (out_taken)
                    sink_wait = steady ? 0 : $urandom_range(0, 3);
                if (sink_wait > 0)
                    sink_wait--;
                else
                    rdy = 1'b1;
            end
        end
        i_out_ready <= rdy;
    end

    task automatic add_cmd(input t_req req, input logic [7:0] idx, input logic [7:0] bri,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_led_cmd c;
        c.req = req;
        c.idx = idx;
        c.bri = bri;
        c.r = r;
        c.g = g;
        c.b = b;
        cmd_backlog.push_back(c);
    endtask

    function automatic t_led_cmd random_cmd();
        t_led_cmd c;
        int pick;
        pick = $urandom_range(0, 99);
        c.idx = 8'($urandom);
        c.bri = 8'($urandom);
        c.r = 8'($urandom);
        c.g = 8'($urandom);
        c.b = 8'($urandom);
        if (pick < 55) begin
            c.req = REQ_SET_ONE;
            c.idx = 8'($urandom_range(0, LEDS - 1));
        end else if (pick < 63) begin
            c.req = REQ_SET_ONE;
            c.idx = 8'($urandom_range(LEDS, 255));
        end else if (pick < 80) begin
            c.req = REQ_SET_ALL;
            // keep half of them near the saturation point
            if ($urandom_range(0, 1) == 0)
                c.bri = 8'($urandom_range(24, 40));
        end else if (pick < 90) begin
            c.req = REQ_ALL_OFF;
        end else begin
            c.req = REQ_NONE;
        end
        return c;
    endfunction

    // Queue n commands that produce output; ignored codes ride along uncounted.
    task automatic queue_random(input int n);
        t_led_cmd c;
        int done;
        done = 0;
        while (done < n) begin
            c = random_cmd();
            cmd_backlog.push_back(c);
            if (c.req != REQ_NONE)
                done++;
        end
    endtask

    // Wait until every command is in and every frame byte is out, then let
    // the block run dry for a frame's worth of cycles.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || offering || frame_bytes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_fill(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(negedge i_clk);
        while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < LEDS; i++) begin
            lvl_model[i] = '0;
            rgb_model[i] = '0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, level masking and saturation, bad indexes,
        // ignored fields on the broadcast commands, and the unused code.
        add_cmd(REQ_SET_ONE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_cmd(REQ_SET_ONE, 8'(LEDS - 1), 8'hFF, 8'hFF, 8'h00, 8'hFF);
        add_cmd(REQ_SET_ONE, 8'd2, 8'hE5, 8'h12, 8'h34, 8'h56);
        add_cmd(REQ_SET_ONE, 8'd1, 8'h20, 8'h80, 8'h7F, 8'h01);
        add_cmd(REQ_SET_ONE, 8'd3, 8'h1F, 8'hAA, 8'h55, 8'hCC);
        add_cmd(REQ_SET_ONE, 8'(LEDS), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(REQ_SET_ONE, 8'hFF, 8'h10, 8'h01, 8'h02, 8'h03);
        add_cmd(REQ_SET_ONE, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
        add_cmd(REQ_SET_ALL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_cmd(REQ_SET_ALL, 8'hFF, 8'd31, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(REQ_SET_ALL, 8'h03, 8'd32, 8'h11, 8'h22, 8'h33);
        add_cmd(REQ_SET_ALL, 8'h40, 8'hFF, 8'h00, 8'h00, 8'h00);
        add_cmd(REQ_NONE, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(REQ_ALL_OFF, 8'd200, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(REQ_SET_ONE, 8'd4, 8'h0A, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(REQ_SET_ALL, 8'hFE, 8'd30, 8'h5A, 8'hA5, 8'h3C);
        add_cmd(REQ_NONE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        add_cmd(REQ_SET_ONE, 8'd5, 8'h11, 8'h00, 8'hFF, 8'h00);
        add_cmd(REQ_ALL_OFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // Random, back to back with no idling on either side.
        write_fill(8'hFF);
        steady = 1'b1;
        queue_random(40);
        wait_idle();

        // Random with idling; the long sink stall lands in this phase.
        write_fill(8'hA5);
        steady = 1'b0;
        queue_random(50);
        wait_idle();

        write_fill(8'h00);
        queue_random(30);
        wait_idle();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: rgb_led_string_frame_builder.f
+incdir+src
src/rlsfb_pkg.sv
src/rlsfb_ram.sv
src/rgb_led_string_frame_builder.sv
bench/rgb_led_string_frame_builder_test.sv
